@@ sv/tsba_pkg.sv @@
`default_nettype none
package tsba_pkg;

   localparam int FUNC_W   = 3;
   localparam int SLOT_W   = 13;
   localparam int SIZE_W   = 14;
   localparam int STATUS_W = 3;
   localparam int CSR_W    = 2;
   localparam int BYTE_W   = 8;

   // Request operations
   localparam logic [FUNC_W-1:0] FUNC_TEST      = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_MARK_POP  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_MARK_FREE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_FIND_FREE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_COUNT     = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_READY = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_POP   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NONE_FREE = 3'd4;

   // Register indexes
   localparam logic [CSR_W-1:0] CSR_ROM_SLOTS  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_DISK_SLOTS = 2'd1;
   localparam logic [CSR_W-1:0] CSR_MAP_READY  = 2'd2;

   localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hff;

endpackage
`default_nettype wire

@@ sv/tsba_map_ram.sv @@
`default_nettype none
module tsba_map_ram #(
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [7:0]               wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [7:0]               rdata
);
   import tsba_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ sv/two_region_slot_bitmap_allocator.sv @@
// Slot requests (test, mark populated, mark free) go through S_SLOT before rsp_valid.
// Not ready, unknown operation and out-of-range slots answer in the cycle after start.
// Find free and count used scan the region bytes inside the map, one byte read per cycle;
// find answers when it reaches a byte that is not full.
// Reset clears the control and configuration registers and sweeps the map to zero,
// one byte per cycle, with busy high. Results are strobed; the receiver cannot stall.
`default_nettype none
module two_region_slot_bitmap_allocator #(
   parameter int MAP_BYTES = 1024
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [tsba_pkg::FUNC_W-1:0]     req_func,
   input  wire logic                            req_slot_kind,
   input  wire logic [tsba_pkg::SLOT_W-1:0]     req_slot_number,
   output logic                                 rsp_valid,
   output logic      [tsba_pkg::STATUS_W-1:0]   rsp_status,
   output logic                                 rsp_populated,
   output logic      [tsba_pkg::SLOT_W-1:0]     rsp_free_slot,
   output logic      [tsba_pkg::SIZE_W-1:0]     rsp_used_count,
   input  wire logic                            csr_we,
   input  wire logic [tsba_pkg::CSR_W-1:0]      csr_index,
   input  wire logic [tsba_pkg::SIZE_W-1:0]     csr_wdata
);
   import tsba_pkg::*;

   localparam int AW       = $clog2(MAP_BYTES);
   localparam int PW       = 17;
   localparam int MAP_BITS = MAP_BYTES * 8;
   localparam int NB_W     = SIZE_W - 3;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_SLOT  = 4'b0100,
      S_SCAN  = 4'b1000
   } state_type;

   function automatic logic [3:0] ones_in_byte(input logic [BYTE_W-1:0] v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         n = n + 4'(v[i]);
      end
      return n;
   endfunction

   function automatic logic [2:0] lowest_zero(input logic [BYTE_W-1:0] v);
      logic [2:0] b;
      b = 3'd7;
      for (int i = BYTE_W - 2; i >= 0; i--) begin
         if (!v[i]) begin
            b = 3'(i);
         end
      end
      return b;
   endfunction

   // Configuration
   logic [SIZE_W-1:0] rom_slots_ff, disk_slots_ff;
   logic              map_ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_slots_ff  <= '0;
         disk_slots_ff <= '0;
         map_ready_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROM_SLOTS:  rom_slots_ff  <= csr_wdata;
            CSR_DISK_SLOTS: disk_slots_ff <= csr_wdata;
            CSR_MAP_READY:  map_ready_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Control and datapath registers
   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [FUNC_W-1:0] func_ff, func_in;
   logic              kind_ff, kind_in;
   logic [2:0]        bit_ff, bit_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [NB_W-1:0]   k_ff, k_in;
   logic              pv_ff, pv_in;
   logic [NB_W-1:0]   pk_ff, pk_in;
   logic [SIZE_W-1:0] used_ff, used_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_pop_ff, rsp_pop_in;
   logic [SLOT_W-1:0]   rsp_free_ff, rsp_free_in;
   logic [SIZE_W-1:0]   rsp_used_ff, rsp_used_in;

   // Memory port
   logic              ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [BYTE_W-1:0] ram_wdata, ram_rdata;

   // Request decode
   logic [SIZE_W-1:0] req_size;
   logic [PW-1:0]     req_p;
   logic              req_out_of_range;
   logic [AW-1:0]     req_addr;

   assign req_size = req_slot_kind ? disk_slots_ff : rom_slots_ff;
   assign req_p    = req_slot_kind ? (PW'(rom_slots_ff) + PW'(req_slot_number))
                                   : PW'(req_slot_number);
   assign req_out_of_range = (SIZE_W'(req_slot_number) >= req_size) ||
                             (req_p >= PW'(MAP_BITS));
   assign req_addr = req_p[AW+2:3];

   // Scan decode
   logic [NB_W-1:0]   scan_nbytes, scan_base;
   logic [SIZE_W-1:0] scan_sum;
   logic              scan_issue;
   logic              byte_full;

   assign scan_nbytes = kind_ff ? disk_slots_ff[SIZE_W-1:3] : rom_slots_ff[SIZE_W-1:3];
   assign scan_base   = kind_ff ? rom_slots_ff[SIZE_W-1:3] : '0;
   assign scan_sum    = SIZE_W'(scan_base) + SIZE_W'(k_ff);
   assign scan_issue  = (k_ff < scan_nbytes) && (scan_sum < SIZE_W'(MAP_BYTES));
   assign byte_full   = (ram_rdata == BYTE_FULL);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      func_in       = func_ff;
      kind_in       = kind_ff;
      bit_in        = bit_ff;
      addr_in       = addr_ff;
      k_in          = k_ff;
      pv_in         = 1'b0;
      pk_in         = pk_ff;
      used_in       = used_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_pop_in    = rsp_pop_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_used_in   = rsp_used_ff;
      ram_we        = 1'b0;
      ram_waddr     = clr_ff;
      ram_wdata     = '0;
      ram_raddr     = req_addr;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(MAP_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               func_in     = req_func;
               kind_in     = req_slot_kind;
               bit_in      = req_p[2:0];
               addr_in     = req_addr;
               k_in        = '0;
               used_in     = '0;
               rsp_pop_in  = 1'b0;
               rsp_free_in = '0;
               rsp_used_in = '0;
               if (!map_ready_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NOT_READY;
               end else if (req_func == FUNC_TEST || req_func == FUNC_MARK_POP ||
                            req_func == FUNC_MARK_FREE) begin
                  if (req_out_of_range) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_RANGE;
                  end else begin
                     state_in = S_SLOT;
                  end
               end else if (req_func == FUNC_FIND_FREE || req_func == FUNC_COUNT) begin
                  state_in = S_SCAN;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_RANGE;
               end
            end
         end

         S_SLOT: begin
            // byte read in the accept cycle is on ram_rdata now
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            state_in      = S_IDLE;
            ram_waddr     = addr_ff;
            ram_wdata     = ram_rdata;
            ram_wdata[bit_ff] = (func_ff == FUNC_MARK_POP);
            if (func_ff == FUNC_TEST) begin
               rsp_pop_in = ram_rdata[bit_ff];
               if (!ram_rdata[bit_ff]) begin
                  rsp_status_in = STATUS_NOT_POP;
               end
            end else begin
               ram_we = 1'b1;
            end
         end

         S_SCAN: begin
            // issue the next byte while the previous one comes back
            ram_raddr = scan_sum[AW-1:0];
            if (scan_issue) begin
               k_in  = k_ff + 1'b1;
               pv_in = 1'b1;
               pk_in = k_ff;
            end
            if (pv_ff && func_ff == FUNC_COUNT) begin
               used_in = used_ff + SIZE_W'(ones_in_byte(ram_rdata));
            end
            if (pv_ff && func_ff == FUNC_FIND_FREE && !byte_full) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_free_in   = SLOT_W'({pk_ff, lowest_zero(ram_rdata)});
               pv_in         = 1'b0;
               state_in      = S_IDLE;
            end else if (!pv_ff && !scan_issue) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (func_ff == FUNC_FIND_FREE) begin
                  rsp_status_in = STATUS_NONE_FREE;
               end else begin
                  rsp_status_in = STATUS_OK;
                  rsp_used_in   = used_ff;
               end
            end
         end

         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      kind_ff       <= kind_in;
      bit_ff        <= bit_in;
      addr_ff       <= addr_in;
      k_ff          <= k_in;
      pk_ff         <= pk_in;
      used_ff       <= used_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pop_ff    <= rsp_pop_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_used_ff   <= rsp_used_in;
   end

   tsba_map_ram #(
      .DEPTH(MAP_BYTES)
   ) u_map_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_populated  = rsp_pop_ff;
   assign rsp_free_slot  = rsp_free_ff;
   assign rsp_used_count = rsp_used_ff;

endmodule
`default_nettype wire

@@ sv/tsba_checker.sv @@
`default_nettype none
module tsba_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          rsp_valid,
   input wire logic [tsba_pkg::STATUS_W-1:0] rsp_status,
   input wire logic                          rsp_populated,
   input wire logic [tsba_pkg::SLOT_W-1:0]   rsp_free_slot
);
   import tsba_pkg::*;

   // the map sweep holds requests off right after reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   a_not_ready_latency: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_NOT_READY) |-> $past(start && !busy))
      else $error("not ready transaction not answered in one cycle");

   a_pop_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_populated) |-> (rsp_status == STATUS_OK))
      else $error("populated set with a failing status");

   a_none_free_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_NONE_FREE) |-> (rsp_free_slot == '0))
      else $error("none free with nonzero slot");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      (!busy && !$past(busy) && !$past(start)) |-> !rsp_valid)
      else $error("response without a transaction");

endmodule

bind two_region_slot_bitmap_allocator tsba_checker u_tsba_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_status   (rsp_status),
   .rsp_populated(rsp_populated),
   .rsp_free_slot(rsp_free_slot)
);
`default_nettype wire
